FILE: sv/sfpf_pkg.sv
// Shared types and constants for the spectral flatness block.
// No dependencies; used by every module of the block.
package sfpf_pkg;

    // Width of one signed spectrum component
    localparam int ITEM_W = 24;
    // Width of the frame length register and the bin counter
    localparam int CNT_W = 13;
    // Fraction bits of the log2 result
    localparam int FRAC_W = 16;
    // Width of the normalised mantissa in the log unit
    localparam int X_W = 24;
    // Width of the squared magnitude before the root
    localparam int RAD_W = 2 * ITEM_W;
    // Number of root iterations
    localparam int ROOT_STEPS = ITEM_W;
    // Number of fraction iterations in the log unit
    localparam int LG_STEPS = FRAC_W;

    // Flatness of 1.0 in Q1.15
    localparam logic [15:0] ONE_Q15 = 16'd32768;
    // Reset value of the frame length register
    localparam logic [CNT_W-1:0] BPF_RESET = 13'd512;
    // Register index of the frame length register
    localparam logic ADDR_BPF = 1'b0;

    // One queued request: absolute values of both components
    typedef struct packed {
        logic [ITEM_W-1:0] abs_re;
        logic [ITEM_W-1:0] abs_im;
    } bin_t;

    // Handshake between the sequencer and the log unit
    typedef struct packed {
        logic done;
        logic busy;
    } lg_stat_t;

endpackage

FILE: sv/sfpf_front.sv
// Front end: takes bins, forms absolute values and queues them.
// Depends on sfpf_pkg.
module sfpf_front
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [sfpf_pkg::ITEM_W-1:0] bin_real,
    input  logic signed [sfpf_pkg::ITEM_W-1:0] bin_imag,
    input  logic                               pop,
    output logic                               not_empty,
    output sfpf_pkg::bin_t                     head
);

    localparam int DEPTH = 4;
    localparam int PW = $clog2(DEPTH);

    sfpf_pkg::bin_t   mem_reg [DEPTH];
    logic [PW-1:0]    wptr_reg, wptr_next;
    logic [PW-1:0]    rptr_reg, rptr_next;
    logic [PW:0]      count_reg, count_next;
    logic             push;
    sfpf_pkg::bin_t   item;

    // Absolute values; the most negative input maps to 2^23 unsigned
    always_comb
    begin
        item.abs_re = bin_real[sfpf_pkg::ITEM_W-1] ? (~bin_real + 1'b1) : bin_real;
        item.abs_im = bin_imag[sfpf_pkg::ITEM_W-1] ? (~bin_imag + 1'b1) : bin_imag;
    end

    assign in_stall  = (count_reg == (PW+1)'(DEPTH));
    assign push      = in_valid && !in_stall;
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wptr_next  = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = pop ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= item;
        end
    end

    // The sequencer only takes a request that is present.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("request taken from an empty queue");

endmodule

FILE: sv/sfpf_lg.sv
// Iterative base-2 logarithm in fixed point, integer part and 16 fraction bits.
// Normalises one bit a cycle, then squares once a cycle. Depends on sfpf_pkg.
module sfpf_lg
#(
    parameter int W = 36
)
(
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        start,
    input  logic [W-1:0]                                arg,
    output sfpf_pkg::lg_stat_t                          stat,
    output logic [$clog2(W)+sfpf_pkg::FRAC_W-1:0]       result
);

    localparam int EW = $clog2(W);
    localparam logic [1:0] L_IDLE = 2'd0;
    localparam logic [1:0] L_NORM = 2'd1;
    localparam logic [1:0] L_SQ   = 2'd2;

    logic [1:0]                     state_reg, state_next;
    logic [W-1:0]                   v_reg, v_next;
    logic [EW-1:0]                  e_reg, e_next;
    logic [sfpf_pkg::X_W-1:0]       x_reg, x_next;
    logic [sfpf_pkg::FRAC_W-1:0]    frac_reg, frac_next;
    logic [3:0]                     k_reg, k_next;
    logic                           done_reg, done_next;
    logic [2*sfpf_pkg::X_W-1:0]     prod;
    logic [sfpf_pkg::X_W:0]         sq;

    // One squaring of the mantissa, Q1.23 back to Q2.23
    assign prod = x_reg * x_reg;
    assign sq   = prod[2*sfpf_pkg::X_W-1 -: sfpf_pkg::X_W+1];

    always_comb
    begin
        state_next = state_reg;
        v_next     = v_reg;
        e_next     = e_reg;
        x_next     = x_reg;
        frac_next  = frac_reg;
        k_next     = k_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            L_IDLE:
            begin
                if (start)
                begin
                    v_next     = arg;
                    e_next     = EW'(W-1);
                    state_next = L_NORM;
                end
            end
            L_NORM:
            begin
                // Shift until the top bit is set, counting down the exponent
                if (v_reg[W-1])
                begin
                    x_next     = v_reg[W-1 -: sfpf_pkg::X_W];
                    frac_next  = '0;
                    k_next     = '0;
                    state_next = L_SQ;
                end
                else
                begin
                    v_next = {v_reg[W-2:0], 1'b0};
                    e_next = e_reg - 1'b1;
                end
            end
            L_SQ:
            begin
                frac_next = {frac_reg[sfpf_pkg::FRAC_W-2:0], sq[sfpf_pkg::X_W]};
                x_next    = sq[sfpf_pkg::X_W] ? sq[sfpf_pkg::X_W:1]
                                              : sq[sfpf_pkg::X_W-1:0];
                k_next    = k_reg + 1'b1;
                if (k_reg == 4'(sfpf_pkg::LG_STEPS-1))
                begin
                    done_next  = 1'b1;
                    state_next = L_IDLE;
                end
            end
            default:
            begin
                state_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg    <= v_next;
        e_reg    <= e_next;
        x_reg    <= x_next;
        frac_reg <= frac_next;
        k_reg    <= k_next;
    end

    assign stat.done = done_reg;
    assign stat.busy = (state_reg != L_IDLE);
    assign result    = {e_reg, frac_reg};

    // A result is only reported once the squaring pass has finished.
    a_done_after_sq: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg) == L_SQ)
        else $error("log result without a squaring pass");

endmodule

FILE: sv/sfpf_back.sv
// Back end: magnitude root, accumulation and the per-frame flatness search.
// Depends on sfpf_pkg and sfpf_lg.
module sfpf_back
#(
    parameter int MAX_BINS = 4096,
    parameter int MSW = 36,
    parameter int LSW = 33
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [sfpf_pkg::CNT_W-1:0]    bins_per_frame,
    input  logic                          not_empty,
    input  sfpf_pkg::bin_t                head,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [15:0]                   flatness,
    output logic                          silent
);

    localparam int CW  = sfpf_pkg::CNT_W;
    localparam int LGW = $clog2(MSW) + sfpf_pkg::FRAC_W;
    localparam int TW  = LGW + 3;
    localparam int ITW = $clog2(LSW + 25);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SQA   = 4'd1;
    localparam logic [3:0] S_SQB   = 4'd2;
    localparam logic [3:0] S_ROOT  = 4'd3;
    localparam logic [3:0] S_ACC   = 4'd4;
    localparam logic [3:0] S_LGM   = 4'd5;
    localparam logic [3:0] S_END   = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_LGN   = 4'd8;
    localparam logic [3:0] S_LGS   = 4'd9;
    localparam logic [3:0] S_SRCH  = 4'd10;
    localparam logic [3:0] S_SRCHW = 4'd11;
    localparam logic [3:0] S_EMIT  = 4'd12;

    logic [3:0]                      state_reg, state_next;
    logic [sfpf_pkg::ITEM_W-1:0]     a_reg, a_next, b_reg, b_next;
    logic [sfpf_pkg::RAD_W-1:0]      prod_reg, prod_next;
    logic [sfpf_pkg::RAD_W-1:0]      rem_reg, rem_next;
    logic [sfpf_pkg::RAD_W-1:0]      res_reg, res_next;
    logic [sfpf_pkg::RAD_W-1:0]      bit_reg, bit_next;
    logic [ITW-1:0]                  it_reg, it_next;
    logic [CW-1:0]                   cnt_reg, cnt_next;
    logic [MSW-1:0]                  msum_reg, msum_next;
    logic [LSW-1:0]                  lsum_reg, lsum_next;
    logic                            zero_reg, zero_next;
    logic [LSW-1:0]                  dq_reg, dq_next;
    logic [CW-1:0]                   drem_reg, drem_next;
    logic [LGW-1:0]                  lgn_reg, lgn_next;
    logic signed [TW-1:0]            t_reg, t_next;
    logic [15:0]                     lo_reg, lo_next, hi_reg, hi_next;
    logic [15:0]                     res_flat_reg, res_flat_next;
    logic                            res_sil_reg, res_sil_next;
    logic                            lg_go_reg, lg_go_next;
    logic [MSW-1:0]                  lg_arg_reg, lg_arg_next;
    logic                            ov_reg, ov_next;
    logic [15:0]                     flat_reg, flat_next;
    logic                            sil_reg, sil_next;

    logic [sfpf_pkg::RAD_W-1:0]      trial;
    logic [CW:0]                     dsh;
    logic [CW-1:0]                   n_eff;
    logic [16:0]                     mid_sum;
    logic [15:0]                     mid;
    logic                            out_free;
    sfpf_pkg::lg_stat_t              lg_stat;
    logic [LGW-1:0]                  lg_res;

    sfpf_lg #(.W(MSW)) u_lg
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (lg_go_reg),
        .arg    (lg_arg_reg),
        .stat   (lg_stat),
        .result (lg_res)
    );

    // Effective frame length: zero reads as one, clamped to the maximum
    always_comb
    begin
        if (bins_per_frame == '0)
        begin
            n_eff = CW'(1);
        end
        else if (32'(bins_per_frame) > MAX_BINS)
        begin
            n_eff = CW'(MAX_BINS);
        end
        else
        begin
            n_eff = bins_per_frame;
        end
    end

    assign trial    = res_reg + bit_reg;
    assign dsh      = {drem_reg, dq_reg[LSW-1]};
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg} + 17'd1;
    assign mid      = mid_sum[16:1];
    assign out_free = !ov_reg || !out_stall;
    assign pop      = (state_reg == S_IDLE) && not_empty;

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        prod_next     = prod_reg;
        rem_next      = rem_reg;
        res_next      = res_reg;
        bit_next      = bit_reg;
        it_next       = it_reg;
        cnt_next      = cnt_reg;
        msum_next     = msum_reg;
        lsum_next     = lsum_reg;
        zero_next     = zero_reg;
        dq_next       = dq_reg;
        drem_next     = drem_reg;
        lgn_next      = lgn_reg;
        t_next        = t_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        res_flat_next = res_flat_reg;
        res_sil_next  = res_sil_reg;
        lg_go_next    = 1'b0;
        lg_arg_next   = lg_arg_reg;
        ov_next       = ov_reg && out_stall;
        flat_next     = flat_reg;
        sil_next      = sil_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (not_empty)
                begin
                    a_next     = head.abs_re;
                    b_next     = head.abs_im;
                    state_next = S_SQA;
                end
            end
            S_SQA:
            begin
                prod_next  = a_reg * a_reg;
                state_next = S_SQB;
            end
            S_SQB:
            begin
                rem_next   = prod_reg + b_reg * b_reg;
                res_next   = '0;
                bit_next   = sfpf_pkg::RAD_W'(1) << (sfpf_pkg::RAD_W - 2);
                it_next    = '0;
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                // One result bit of the integer square root per cycle
                if (rem_reg >= trial)
                begin
                    rem_next = rem_reg - trial;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                it_next  = it_reg + 1'b1;
                if (it_reg == ITW'(sfpf_pkg::ROOT_STEPS-1))
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                msum_next = msum_reg + MSW'(res_reg[sfpf_pkg::ITEM_W-1:0]);
                if (res_reg[sfpf_pkg::ITEM_W-1:0] == '0)
                begin
                    zero_next  = 1'b1;
                    state_next = S_END;
                end
                else
                begin
                    lg_go_next  = 1'b1;
                    lg_arg_next = MSW'(res_reg[sfpf_pkg::ITEM_W-1:0]);
                    state_next  = S_LGM;
                end
            end
            S_LGM:
            begin
                if (lg_stat.done)
                begin
                    lsum_next  = lsum_reg + LSW'(lg_res);
                    state_next = S_END;
                end
            end
            S_END:
            begin
                // Frame ends when the count reaches or passes the length
                if ({1'b0, cnt_reg} + (CW+1)'(1) < {1'b0, n_eff})
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_IDLE;
                end
                else if (msum_reg == '0)
                begin
                    res_flat_next = sfpf_pkg::ONE_Q15;
                    res_sil_next  = 1'b1;
                    state_next    = S_EMIT;
                end
                else if (zero_reg)
                begin
                    res_flat_next = '0;
                    res_sil_next  = 1'b0;
                    state_next    = S_EMIT;
                end
                else
                begin
                    dq_next    = lsum_reg;
                    drem_next  = '0;
                    it_next    = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                // Restoring division of the log sum by the frame length
                if (dsh >= {1'b0, n_eff})
                begin
                    drem_next = CW'(dsh - {1'b0, n_eff});
                    dq_next   = {dq_reg[LSW-2:0], 1'b1};
                end
                else
                begin
                    drem_next = dsh[CW-1:0];
                    dq_next   = {dq_reg[LSW-2:0], 1'b0};
                end
                it_next = it_reg + 1'b1;
                if (it_reg == ITW'(LSW-1))
                begin
                    lg_go_next  = 1'b1;
                    lg_arg_next = MSW'(n_eff);
                    state_next  = S_LGN;
                end
            end
            S_LGN:
            begin
                if (lg_stat.done)
                begin
                    lgn_next    = lg_res;
                    lg_go_next  = 1'b1;
                    lg_arg_next = msum_reg;
                    state_next  = S_LGS;
                end
            end
            S_LGS:
            begin
                if (lg_stat.done)
                begin
                    t_next = $signed(TW'(dq_reg)) + $signed({3'b000, lgn_reg})
                           - $signed({3'b000, lg_res}) + $signed(TW'(15 * 65536));
                    lo_next    = '0;
                    hi_next    = sfpf_pkg::ONE_Q15;
                    state_next = S_SRCH;
                end
            end
            S_SRCH:
            begin
                // Binary search for the largest y with lg(y) within the target
                if (lo_reg < hi_reg)
                begin
                    lg_go_next  = 1'b1;
                    lg_arg_next = MSW'(mid);
                    state_next  = S_SRCHW;
                end
                else
                begin
                    res_flat_next = lo_reg;
                    res_sil_next  = 1'b0;
                    state_next    = S_EMIT;
                end
            end
            S_SRCHW:
            begin
                if (lg_stat.done)
                begin
                    if ($signed({3'b000, lg_res}) <= t_reg)
                    begin
                        lo_next = mid;
                    end
                    else
                    begin
                        hi_next = mid - 1'b1;
                    end
                    state_next = S_SRCH;
                end
            end
            S_EMIT:
            begin
                // Hand the result over and clear the frame accumulators
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    flat_next  = res_flat_reg;
                    sil_next   = res_sil_reg;
                    cnt_next   = '0;
                    msum_next  = '0;
                    lsum_next  = '0;
                    zero_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            msum_reg  <= '0;
            lsum_reg  <= '0;
            zero_reg  <= 1'b0;
            lg_go_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            msum_reg  <= msum_next;
            lsum_reg  <= lsum_next;
            zero_reg  <= zero_next;
            lg_go_reg <= lg_go_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        b_reg        <= b_next;
        prod_reg     <= prod_next;
        rem_reg      <= rem_next;
        res_reg      <= res_next;
        bit_reg      <= bit_next;
        it_reg       <= it_next;
        dq_reg       <= dq_next;
        drem_reg     <= drem_next;
        lgn_reg      <= lgn_next;
        t_reg        <= t_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        res_flat_reg <= res_flat_next;
        res_sil_reg  <= res_sil_next;
        lg_arg_reg   <= lg_arg_next;
        flat_reg     <= flat_next;
        sil_reg      <= sil_next;
    end

    assign out_valid = ov_reg;
    assign flatness  = flat_reg;
    assign silent    = sil_reg;

    // A silent frame always reports full flatness.
    a_silent_one: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && sil_reg) |-> (flat_reg == sfpf_pkg::ONE_Q15))
        else $error("silent frame without full flatness");

    // Flatness never exceeds 1.0.
    a_flat_range: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> (flat_reg <= sfpf_pkg::ONE_Q15))
        else $error("flatness above 1.0");

endmodule

FILE: sv/spectral_flatness_per_frame.sv
// Spectral flatness per frame: bins queue in a four-entry front end, a sequencer works them.
// Each bin goes through the squares, the root loop and, if it is nonzero, a pass of the log unit.
// A new bin is taken from the queue only once the last one is done; the log unit is shared.
// Frame end adds a restoring division of the log sum and up to 18 passes of the log unit.
// Reset clears the accumulators and the queue, and sets the frame length to 512.
module spectral_flatness_per_frame
#(
    parameter int MAX_BINS = 4096
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [sfpf_pkg::ITEM_W-1:0] bin_real,
    input  logic signed [sfpf_pkg::ITEM_W-1:0] bin_imag,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [15:0]                        flatness,
    output logic                               silent
);

    localparam int MSW = sfpf_pkg::ITEM_W + $clog2(MAX_BINS);
    localparam int LSW = 21 + $clog2(MAX_BINS);

    logic [sfpf_pkg::CNT_W-1:0] bpf_reg, bpf_next;
    logic                       not_empty;
    logic                       pop;
    sfpf_pkg::bin_t             head;

    // Configuration register write and read back
    assign pready = 1'b1;
    always_comb
    begin
        bpf_next = bpf_reg;
        if (psel && penable && pwrite && (paddr[2] == sfpf_pkg::ADDR_BPF))
        begin
            bpf_next = pwdata[sfpf_pkg::CNT_W-1:0];
        end
    end
    assign prdata = (paddr[2] == sfpf_pkg::ADDR_BPF) ? 32'(bpf_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpf_reg <= sfpf_pkg::BPF_RESET;
        end
        else
        begin
            bpf_reg <= bpf_next;
        end
    end

    sfpf_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .bin_real  (bin_real),
        .bin_imag  (bin_imag),
        .pop       (pop),
        .not_empty (not_empty),
        .head      (head)
    );

    sfpf_back #(.MAX_BINS(MAX_BINS), .MSW(MSW), .LSW(LSW)) u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .bins_per_frame (bpf_reg),
        .not_empty      (not_empty),
        .head           (head),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .flatness       (flatness),
        .silent         (silent)
    );

endmodule
